/* src/fpft_pkg.sv */
package fpft_pkg;

  // Field widths
  localparam int COORD_BITS = 24;
  localparam int TOL_W      = 24;
  localparam int OP_W       = 3;
  localparam int KIND_W     = 3;
  localparam int IDX_W      = 16;
  localparam int TOT_W      = 17;

  // Point compare: signed difference and the magnitude compare width
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int ABS_W  = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;

  // Defaults for the top-level parameters and the tolerance register
  localparam int                DEF_MAX_VERTICES       = 65536;
  localparam int                DEF_MAX_SHAPE_VERTICES = 64;
  localparam logic [TOL_W-1:0]  TOL_RESET              = TOL_W'(128);

  // Path command codes
  typedef enum logic [OP_W-1:0] {
    OP_BEGIN = 3'd0,
    OP_MOVE  = 3'd1,
    OP_LINE  = 3'd2,
    OP_CLOSE = 3'd3,
    OP_END   = 3'd4
  } op_e;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_VERTEX   = 3'd0,
    KIND_TRIANGLE = 3'd1,
    KIND_SHAPE_RB = 3'd2,
    KIND_DRAW_RB  = 3'd3,
    KIND_DRAW     = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_e;

  // Input request
  typedef struct packed {
    logic [OP_W-1:0]              operation;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [KIND_W-1:0]            kind;
    logic [IDX_W-1:0]             vertex_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic [IDX_W-1:0]             corner_a;
    logic [IDX_W-1:0]             corner_b;
    logic [IDX_W-1:0]             corner_c;
    logic [TOT_W-1:0]             vertex_total;
    logic [TOT_W-1:0]             triangle_total;
    logic                         last;
  } res_t;

endpackage

/* src/fill_path_fan_tessellator.sv */
// Fill-path fan tessellator.
// Input channel (in_valid_i/in_ready_o, in_data_i): one path command per request
// (begin, move to, line to, close, end) with a signed Q16.8 target point.
// Output channel (out_valid_o/out_ready_i, out_data_o): vertices, overflow marks,
// fan triangles, shape and draw rollbacks and draw records; the final result of
// a command carries last.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i): merge tolerance, always
// ready, to be written only while no command is in flight.
// One command is worked on at a time; in_ready_o is high only when idle.
// A close, asked for or implied by a move or an end, emits the closing vertex
// and checks the shape size when the shape has lines, then gives a rollback or
// a fan of n - 2 triangles over n vertices.
// The fan loop emits one triangle per cycle while the output is free; the point compare is one shared
// subtract/abs/compare unit used for x and then y.
// A result sits in one output register; while the receiver stalls, a state that
// emits waits on that register, and the input stays not ready until idle.
// Reset clears all counts, the current point and the output register and sets
// the tolerance to 128 (0.5 in Q16.8).
module fill_path_fan_tessellator
  import fpft_pkg::*;
#(
  parameter int MAX_VERTICES       = DEF_MAX_VERTICES,
  parameter int MAX_SHAPE_VERTICES = DEF_MAX_SHAPE_VERTICES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [TOL_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cmd_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output res_t             out_data_o
);

  localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W  = (VCNT_W > 7) ? VCNT_W : 7;

  typedef enum logic [1:0] {
    STEP_CLOSE = 2'd0,
    STEP_MOVE  = 2'd1,
    STEP_LINE  = 2'd2
  } step_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LN_DX,
    ST_LN_DY,
    ST_CL_VTX,
    ST_CL_CHK,
    ST_CL_RB,
    ST_CL_FAN,
    ST_POST
  } state_e;

  state_e                state_q, state_d;
  step_e                 prev_q, prev_d;
  cmd_t                  cmd_q, cmd_d;
  logic [TOL_W-1:0]      tol_q, tol_d;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [VCNT_W-1:0]     vc_q, vc_d, tc_q, tc_d;
  logic [VCNT_W-1:0]     ssv_q, ssv_d, sst_q, sst_d;
  logic [VCNT_W-1:0]     dsv_q, dsv_d, dst_q, dst_d;
  logic [VCNT_W-1:0]     fan_q, fan_d;
  logic                  near_x_q, near_x_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_q, out_d;

  logic                  fire;
  logic                  emit;
  res_t                  res;
  logic                  vtx_ovf;
  logic [VCNT_W-1:0]     shape_n;
  logic                  close_last;
  state_e                close_next;
  state_e                close_entry;

  logic signed [COORD_BITS-1:0] unit_a, unit_b;
  logic signed [DIFF_W-1:0]     unit_diff;
  logic [DIFF_W-1:0]            unit_abs;
  logic                         unit_lt;

  // Shared point compare unit: x in ST_LN_DX, y otherwise
  assign unit_a    = (state_q == ST_LN_DX) ? cmd_q.coord_x : cmd_q.coord_y;
  assign unit_b    = (state_q == ST_LN_DX) ? cur_x_q : cur_y_q;
  assign unit_diff = DIFF_W'(unit_a) - DIFF_W'(unit_b);
  assign unit_abs  = unit_diff[DIFF_W-1] ? DIFF_W'(-unit_diff) : DIFF_W'(unit_diff);
  assign unit_lt   = ABS_W'(unit_abs) < ABS_W'(tol_q);

  // Capacity check for the next vertex
  assign shape_n = vc_q - ssv_q;
  assign vtx_ovf = (CMP_W'(shape_n) >= CMP_W'(MAX_SHAPE_VERTICES)) ||
                   (vc_q >= VCNT_W'(MAX_VERTICES));

  // What follows a close depends on the command that caused it
  assign close_last  = (cmd_q.operation != OP_END);
  assign close_next  = ((cmd_q.operation == OP_MOVE) || (cmd_q.operation == OP_END)) ?
                       ST_POST : ST_IDLE;
  assign close_entry = (prev_q == STEP_LINE) ? ST_CL_VTX : ST_CL_RB;

  assign fire        = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    prev_d   = prev_q;
    cmd_d    = cmd_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    vc_d     = vc_q;
    tc_d     = tc_q;
    ssv_d    = ssv_q;
    sst_d    = sst_q;
    dsv_d    = dsv_q;
    dst_d    = dst_q;
    fan_d    = fan_q;
    near_x_d = near_x_q;
    emit     = 1'b0;
    res      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i;
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        unique case (cmd_q.operation)
          OP_BEGIN: begin
            prev_d  = STEP_CLOSE;
            dsv_d   = vc_q;
            dst_d   = tc_q;
            ssv_d   = vc_q;
            sst_d   = tc_q;
            state_d = ST_IDLE;
          end
          OP_MOVE, OP_END: begin
            state_d = (prev_q == STEP_CLOSE) ? ST_POST : close_entry;
          end
          OP_LINE: begin
            // a line after a close starts a shape at its own target
            if (prev_q == STEP_CLOSE) begin
              prev_d  = STEP_MOVE;
              cur_x_d = cmd_q.coord_x;
              cur_y_d = cmd_q.coord_y;
              ssv_d   = vc_q;
              sst_d   = tc_q;
            end
            state_d = ST_LN_DX;
          end
          OP_CLOSE: state_d = close_entry;
          default:  state_d = ST_IDLE;
        endcase
      end

      ST_LN_DX: begin
        near_x_d = unit_lt;
        state_d  = ST_LN_DY;
      end

      ST_LN_DY: begin
        if (near_x_q && unit_lt) begin
          state_d = ST_IDLE;
        end else if (fire) begin
          emit             = 1'b1;
          res.kind         = vtx_ovf ? KIND_OVERFLOW : KIND_VERTEX;
          res.vertex_index = IDX_W'(vc_q);
          res.pos_x        = cur_x_q;
          res.pos_y        = cur_y_q;
          res.last         = 1'b1;
          if (!vtx_ovf) vc_d = vc_q + VCNT_W'(1);
          prev_d  = STEP_LINE;
          cur_x_d = cmd_q.coord_x;
          cur_y_d = cmd_q.coord_y;
          state_d = ST_IDLE;
        end
      end

      ST_CL_VTX: begin
        // closing vertex, never the last result of the close
        if (fire) begin
          emit             = 1'b1;
          res.kind         = vtx_ovf ? KIND_OVERFLOW : KIND_VERTEX;
          res.vertex_index = IDX_W'(vc_q);
          res.pos_x        = cur_x_q;
          res.pos_y        = cur_y_q;
          if (!vtx_ovf) vc_d = vc_q + VCNT_W'(1);
          state_d = ST_CL_CHK;
        end
      end

      ST_CL_CHK: begin
        if (shape_n < VCNT_W'(3)) begin
          state_d = ST_CL_RB;
        end else begin
          fan_d   = ssv_q + VCNT_W'(1);
          state_d = ST_CL_FAN;
        end
      end

      ST_CL_RB: begin
        if (fire) begin
          emit               = 1'b1;
          res.kind           = KIND_SHAPE_RB;
          res.vertex_total   = TOT_W'(ssv_q);
          res.triangle_total = TOT_W'(sst_q);
          res.last           = close_last;
          vc_d    = ssv_q;
          tc_d    = sst_q;
          prev_d  = STEP_CLOSE;
          state_d = close_next;
        end
      end

      ST_CL_FAN: begin
        // one fan triangle per cycle while the output is free: (origin, i, i+1)
        if (fire) begin
          emit         = 1'b1;
          res.kind     = KIND_TRIANGLE;
          res.corner_a = IDX_W'(ssv_q);
          res.corner_b = IDX_W'(fan_q);
          res.corner_c = IDX_W'(fan_q + VCNT_W'(1));
          tc_d  = tc_q + VCNT_W'(1);
          fan_d = fan_q + VCNT_W'(1);
          if ((fan_q + VCNT_W'(2)) == vc_q) begin
            res.last = close_last;
            prev_d   = STEP_CLOSE;
            ssv_d    = vc_q;
            sst_d    = tc_q + VCNT_W'(1);
            state_d  = close_next;
          end
        end
      end

      ST_POST: begin
        if (cmd_q.operation == OP_MOVE) begin
          prev_d  = STEP_MOVE;
          cur_x_d = cmd_q.coord_x;
          cur_y_d = cmd_q.coord_y;
          ssv_d   = vc_q;
          sst_d   = tc_q;
          state_d = ST_IDLE;
        end else if (fire) begin
          // end: draw record, or rollback of an empty draw
          emit     = 1'b1;
          res.last = 1'b1;
          if ((tc_q == dst_q) || (vc_q == dsv_q)) begin
            res.kind           = KIND_DRAW_RB;
            res.vertex_total   = TOT_W'(dsv_q);
            res.triangle_total = TOT_W'(dst_q);
            vc_d  = dsv_q;
            tc_d  = dst_q;
            ssv_d = dsv_q;
            sst_d = dst_q;
          end else begin
            res.kind           = KIND_DRAW;
            res.vertex_total   = TOT_W'(vc_q);
            res.triangle_total = TOT_W'(tc_q);
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Tolerance register
  assign tol_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : tol_q;

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= STEP_CLOSE;
      cmd_q       <= '0;
      tol_q       <= TOL_RESET;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      vc_q        <= '0;
      tc_q        <= '0;
      ssv_q       <= '0;
      sst_q       <= '0;
      dsv_q       <= '0;
      dst_q       <= '0;
      fan_q       <= '0;
      near_x_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      cmd_q       <= cmd_d;
      tol_q       <= tol_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      vc_q        <= vc_d;
      tc_q        <= tc_d;
      ssv_q       <= ssv_d;
      sst_q       <= sst_d;
      dsv_q       <= dsv_d;
      dst_q       <= dst_d;
      fan_q       <= fan_d;
      near_x_q    <= near_x_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Shape start never runs ahead of the vertex count
  a_shape_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ssv_q <= vc_q) else $error("shape start beyond vertex count");

  // The triangle count never runs beyond the vertex count
  a_tri_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tc_q <= vc_q) else $error("triangle count beyond vertex count");

  // Vertex count stays within capacity
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q <= VCNT_W'(MAX_VERTICES)) else $error("vertex count beyond capacity");

  // Fan index always leaves room for the third corner
  a_fan_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CL_FAN) |-> ((fan_q + VCNT_W'(1)) < vc_q))
    else $error("fan index out of range");

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit) else $error("result overwritten");

endmodule

/* bench/fpft_fan_checker.sv */
// Watches the three channels of the fan tessellator, predicts every result of
// each accepted request and compares the results in order, field by field.
module fpft_fan_checker
  import fpft_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [TOL_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  cmd_t             in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  res_t             out_data_i,
  output int               fault_count_o,
  output int               awaited_o
);

  typedef enum logic [1:0] {
    STEP_CLOSE,
    STEP_MOVE,
    STEP_LINE
  } step_e;

  // Predicted block state
  logic [TOL_W-1:0]             tolerance;
  step_e                        step;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  int unsigned                  vtx_count;
  int unsigned                  tri_count;
  int unsigned                  shape_vtx;
  int unsigned                  shape_tri;
  int unsigned                  draw_vtx;
  int unsigned                  draw_tri;

  // Results still owed by the block, oldest first
  res_t due_results[$];
  // Newest result of the current request, held back until we know if it is last
  res_t held;
  bit   held_valid;
  res_t want;

  task automatic queue_result(input kind_e k, input int unsigned idx,
                              input logic signed [COORD_BITS-1:0] px,
                              input logic signed [COORD_BITS-1:0] py,
                              input int unsigned ca, input int unsigned cb,
                              input int unsigned cc, input int unsigned vt,
                              input int unsigned tt);
    res_t r;
    r                = '0;
    r.kind           = k;
    r.vertex_index   = IDX_W'(idx);
    r.pos_x          = px;
    r.pos_y          = py;
    r.corner_a       = IDX_W'(ca);
    r.corner_b       = IDX_W'(cb);
    r.corner_c       = IDX_W'(cc);
    r.vertex_total   = TOT_W'(vt);
    r.triangle_total = TOT_W'(tt);
    if (held_valid) due_results.insert(due_results.size(), held);
    held       = r;
    held_valid = 1'b1;
  endtask

  // Vertex, or an overflow mark when the shape or the draw stream is full
  task automatic emit_vertex(input logic signed [COORD_BITS-1:0] px,
                             input logic signed [COORD_BITS-1:0] py);
    if (vtx_count - shape_vtx >= DEF_MAX_SHAPE_VERTICES ||
        vtx_count >= DEF_MAX_VERTICES) begin
      queue_result(KIND_OVERFLOW, vtx_count, px, py, 0, 0, 0, 0, 0);
    end else begin
      queue_result(KIND_VERTEX, vtx_count, px, py, 0, 0, 0, 0, 0);
      vtx_count++;
    end
  endtask

  task automatic shape_rollback();
    vtx_count = shape_vtx;
    tri_count = shape_tri;
    queue_result(KIND_SHAPE_RB, 0, '0, '0, 0, 0, 0, vtx_count, tri_count);
  endtask

  // Last vertex then a fan from the shape's first vertex, or a shape rollback
  task automatic close_shape();
    int unsigned i;
    if (step == STEP_LINE) begin
      emit_vertex(cur_x, cur_y);
      if (vtx_count - shape_vtx < 3) begin
        shape_rollback();
      end else begin
        for (i = shape_vtx + 1; i + 1 < vtx_count; i++) begin
          queue_result(KIND_TRIANGLE, 0, '0, '0, shape_vtx, i, i + 1, 0, 0);
          tri_count++;
        end
      end
    end else begin
      shape_rollback();
    end
    step      = STEP_CLOSE;
    shape_vtx = vtx_count;
    shape_tri = tri_count;
  endtask

  task automatic move_to(input logic signed [COORD_BITS-1:0] px,
                         input logic signed [COORD_BITS-1:0] py);
    if (step == STEP_LINE || step == STEP_MOVE) close_shape();
    step      = STEP_MOVE;
    cur_x     = px;
    cur_y     = py;
    shape_vtx = vtx_count;
    shape_tri = tri_count;
  endtask

  function automatic bit is_merged(input logic signed [COORD_BITS-1:0] px,
                                   input logic signed [COORD_BITS-1:0] py);
    longint dx;
    longint dy;
    dx = longint'(px) - longint'(cur_x);
    dy = longint'(py) - longint'(cur_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx < longint'(tolerance) && dy < longint'(tolerance);
  endfunction

  // Works out every result that one accepted request causes
  task automatic tessellate_cmd(input cmd_t c);
    case (c.operation)
      OP_BEGIN: begin
        step      = STEP_CLOSE;
        draw_vtx  = vtx_count;
        draw_tri  = tri_count;
        shape_vtx = vtx_count;
        shape_tri = tri_count;
      end
      OP_MOVE: begin
        move_to(c.coord_x, c.coord_y);
      end
      OP_LINE: begin
        if (step == STEP_CLOSE) move_to(c.coord_x, c.coord_y);
        if (!is_merged(c.coord_x, c.coord_y)) begin
          step = STEP_LINE;
          emit_vertex(cur_x, cur_y);
          cur_x = c.coord_x;
          cur_y = c.coord_y;
        end
      end
      OP_CLOSE: begin
        close_shape();
      end
      OP_END: begin
        if (step == STEP_LINE || step == STEP_MOVE) close_shape();
        if (tri_count == draw_tri || vtx_count == draw_vtx) begin
          vtx_count = draw_vtx;
          tri_count = draw_tri;
          shape_vtx = vtx_count;
          shape_tri = tri_count;
          queue_result(KIND_DRAW_RB, 0, '0, '0, 0, 0, 0, vtx_count, tri_count);
        end else begin
          queue_result(KIND_DRAW, 0, '0, '0, 0, 0, 0, vtx_count, tri_count);
        end
      end
      default: begin
        // spare codes are ignored by the block
      end
    endcase
    if (held_valid) begin
      held.last = 1'b1;
      due_results.insert(due_results.size(), held);
      held_valid = 1'b0;
    end
  endtask

  task automatic check_field(input string label, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      fault_count_o++;
      $display("%0t: %s expected %0h, got %0h", $time, label, want_v, got_v);
    end
  endtask

  // Model update and comparison, both at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance     = TOL_RESET;
      step          = STEP_CLOSE;
      cur_x         = '0;
      cur_y         = '0;
      vtx_count     = 0;
      tri_count     = 0;
      shape_vtx     = 0;
      shape_tri     = 0;
      draw_vtx      = 0;
      draw_tri      = 0;
      held_valid    = 1'b0;
      due_results.delete();
      fault_count_o = 0;
      awaited_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) tolerance = cfg_data_i;
      if (in_valid_i && in_ready_i) tessellate_cmd(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          fault_count_o++;
          $display("%0t: result with nothing expected, expected none, got %h",
                   $time, out_data_i);
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, out_data_i.kind);
          check_field("vertex_index", want.vertex_index, out_data_i.vertex_index);
          check_field("pos_x", want.pos_x, out_data_i.pos_x);
          check_field("pos_y", want.pos_y, out_data_i.pos_y);
          check_field("corner_a", want.corner_a, out_data_i.corner_a);
          check_field("corner_b", want.corner_b, out_data_i.corner_b);
          check_field("corner_c", want.corner_c, out_data_i.corner_c);
          check_field("vertex_total", want.vertex_total, out_data_i.vertex_total);
          check_field("triangle_total", want.triangle_total,
                      out_data_i.triangle_total);
          check_field("last", want.last, out_data_i.last);
        end
      end
      awaited_o = due_results.size();
    end
  end

endmodule

/* bench/fill_path_fan_tessellator_tb.sv */
// Stimulus and verdict for the fan tessellator; checking is done by the
// checker instance beside the block.
module fill_path_fan_tessellator_tb;
  import fpft_pkg::*;

  // Watchdog limit for a full run, even with every request at its most results
  // and the receiver stalling half the time
  localparam int CYCLE_LIMIT = 200_000;
  localparam int OP_CODES    = 1 << OP_W;
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [TOL_W-1:0]             TOL_MAX = '1;

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [TOL_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  cmd_t             in_data;
  logic             out_valid;
  logic             out_ready = 1'b0;
  res_t             out_data;
  int               fault_count;
  int               awaited;

  int               snd_idle = 0;
  int               rcv_idle = 0;
  int               cmd_count = 0;
  int               cycle_count;
  logic signed [COORD_BITS-1:0] last_x = '0;
  logic signed [COORD_BITS-1:0] last_y = '0;

  fill_path_fan_tessellator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  fpft_fan_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .fault_count_o (fault_count),
    .awaited_o     (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fill_path_fan_tessellator_tb NOT OK");
    $finish;
  end

  function automatic logic signed [COORD_BITS-1:0] corner_coord();
    case ($urandom_range(0, 2))
      0:       return C_MIN;
      1:       return C_MAX;
      default: return '0;
    endcase
  endfunction

  // Mostly full-range points, some near the previous one, some at the extremes
  task automatic pick_point(output logic signed [COORD_BITS-1:0] px,
                            output logic signed [COORD_BITS-1:0] py);
    int mode;
    int off_x;
    int off_y;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      px = corner_coord();
      py = corner_coord();
    end else if (mode <= 3) begin
      off_x = int'($urandom_range(0, 600)) - 300;
      off_y = int'($urandom_range(0, 600)) - 300;
      px    = last_x + COORD_BITS'(off_x);
      py    = last_y + COORD_BITS'(off_y);
    end else begin
      px = COORD_BITS'($urandom);
      py = COORD_BITS'($urandom);
    end
    last_x = px;
    last_y = py;
  endtask

  // One request; entered and left at a falling edge, valid held until taken
  task automatic send_cmd(input logic [OP_W-1:0] op,
                          input logic signed [COORD_BITS-1:0] x,
                          input logic signed [COORD_BITS-1:0] y);
    cmd_t c;
    c.operation = op;
    c.coord_x   = x;
    c.coord_y   = y;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op <= OP_END) cmd_count++;
  endtask

  // Wait for every owed result, then for any request that gives none
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed paths with random content, the rest loose requests
  task automatic random_paths(input int quota);
    int start;
    int k;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    start = cmd_count;
    while (cmd_count - start < quota) begin
      if ($urandom_range(0, 99) < 70) begin
        pick_point(px, py);
        if ($urandom_range(0, 3) == 0) send_cmd(OP_BEGIN, px, py);
        if ($urandom_range(0, 4) != 0) send_cmd(OP_MOVE, px, py);
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
        repeat (k) begin
          pick_point(px, py);
          send_cmd(OP_LINE, px, py);
        end
        case ($urandom_range(0, 3))
          0, 1:    send_cmd(OP_CLOSE, px, py);
          2:       send_cmd(OP_END, px, py);
          default: ;
        endcase
      end else begin
        pick_point(px, py);
        send_cmd(OP_W'($urandom_range(0, OP_CODES - 1)), px, py);
      end
    end
  endtask

  initial begin
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sender idles a quarter of the time, receiver about half
    snd_idle = 25;
    rcv_idle = 49;

    // Directed requests at the reset tolerance
    send_cmd(OP_END, '0, '0);                    // empty draw
    send_cmd(OP_CLOSE, '0, '0);                  // close with no open shape
    send_cmd(OP_BEGIN, '0, '0);
    send_cmd(OP_MOVE, C_MAX, C_MAX);
    send_cmd(OP_LINE, C_MIN, C_MIN);
    send_cmd(OP_LINE, COORD_BITS'(C_MIN + 127),
             COORD_BITS'(C_MIN + 127));          // just inside tolerance
    send_cmd(OP_LINE, COORD_BITS'(C_MIN + 128), C_MIN); // just outside on x
    send_cmd(OP_LINE, '0, '0);
    send_cmd(OP_CLOSE, '0, '0);                  // four vertices, two triangles
    send_cmd(OP_LINE, 1280, 1792);               // implicit move, then merged
    send_cmd(OP_LINE, '0, -1);
    send_cmd(OP_CLOSE, '0, '0);                  // two vertices: rolled back
    send_cmd(OP_MOVE, 100, 100);
    send_cmd(OP_MOVE, -100, -100);               // empty shape rolled back
    for (int u = int'(OP_END) + 1; u < OP_CODES; u++)
      send_cmd(OP_W'(u), C_MAX, C_MIN);
    send_cmd(OP_LINE, '0, 4096);
    send_cmd(OP_LINE, 4096, 4096);
    send_cmd(OP_BEGIN, '0, '0);                  // abandons the open shape
    send_cmd(OP_LINE, '0, '0);
    send_cmd(OP_LINE, 256, '0);
    send_cmd(OP_LINE, 256, 256);
    send_cmd(OP_END, '0, '0);                    // closes, then draw record
    send_cmd(OP_END, '0, '0);                    // same draw record again
    send_cmd(OP_MOVE, 512, 512);
    send_cmd(OP_END, '0, '0);                    // end straight after a move

    settle();
    write_tolerance('0);
    random_paths(8);

    // Roles swapped; widest tolerance first
    settle();
    snd_idle = 49;
    rcv_idle = 25;
    write_tolerance(TOL_MAX);
    send_cmd(OP_MOVE, C_MIN, C_MIN);
    send_cmd(OP_LINE, C_MAX, C_MAX);
    send_cmd(OP_LINE, C_MIN, '0);
    send_cmd(OP_LINE, '0, '0);
    send_cmd(OP_CLOSE, '0, '0);
    settle();
    write_tolerance(TOL_W'($urandom_range(1, 4096)));
    random_paths(8);

    // No idling from here on
    settle();
    snd_idle = 0;
    rcv_idle = 0;
    write_tolerance(TOL_W'($urandom_range(1, 65536)));
    random_paths(6);

    // Capacity: one shape filled past its limit, closed by the end
    settle();
    write_tolerance('0);
    send_cmd(OP_BEGIN, '0, '0);
    pick_point(px, py);
    send_cmd(OP_MOVE, px, py);
    repeat (DEF_MAX_SHAPE_VERTICES + 2) begin
      pick_point(px, py);
      send_cmd(OP_LINE, px, py);
    end
    send_cmd(OP_END, px, py);

    // Drain and verdict
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fault_count == 0 && awaited == 0) begin
      $display("fill_path_fan_tessellator_tb OK");
    end else begin
      $display("fill_path_fan_tessellator_tb NOT OK");
    end
    $finish;
  end

endmodule
